@@ rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared constants and the front-to-back command type.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int CmdQueueDepth = 4;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// One command per accepted item that does something.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} sha1_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

endpackage

@@ rtl/sha1_hash_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-serial SHA-1 with a command queue in front of the compression core.
// ----------------------------------------------------------------------------
// A byte item is queued and, once the back end is idle, absorbed into the block; a
//   byte that completes a block adds the 80 rounds, then the fold.
// The back end takes no item while a block is compressed; the queue holds items meanwhile.
// A last item leads to one or two padded blocks before the digest.
// Reset (arst_n low) clears the queue, restores the initial vector, count zero.
module sha1_hash_engine #(
	parameter int CmdDepth = sha1_pkg::CmdQueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4
);
	logic                cmd_valid, cmd_take;
	sha1_pkg::sha1_cmd_t cmd;

	// front: items without byte or last are dropped here
	sha1_front #(.Depth(CmdDepth)) u_front (
		.clk, .arst_n, .push, .full, .data_byte, .has_byte, .last,
		.cmd_valid, .cmd_take, .cmd
	);

	// back: packing, padding, rounds and the digest output register
	sha1_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd, .empty, .pop,
		.digest_word0, .digest_word1, .digest_word2, .digest_word3, .digest_word4
	);
endmodule

@@ rtl/sha1_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts items, drops empty ones, queues commands for the back end.
// ----------------------------------------------------------------------------
module sha1_front #(
	parameter int Depth = sha1_pkg::CmdQueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               has_byte,
	input  logic               last,
	output logic               cmd_valid,
	input  logic               cmd_take,
	output sha1_pkg::sha1_cmd_t cmd
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha1_pkg::sha1_cmd_t fifo_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          wr_en, rd_en;

	assign full      = (cnt_q == (AW+1)'(Depth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];
	assign wr_en     = push && !full && (has_byte || last);
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_q] <= '{data_byte: data_byte, has_byte: has_byte, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end
endmodule

@@ rtl/sha1_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes, pads, runs 80 rounds per block, holds the digest.
// ----------------------------------------------------------------------------
module sha1_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_take,
	input  sha1_pkg::sha1_cmd_t cmd,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         digest_word0,
	output logic [31:0]         digest_word1,
	output logic [31:0]         digest_word2,
	output logic [31:0]         digest_word3,
	output logic [31:0]         digest_word4
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_RUN   = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_OUT   = 6'b100000
	} st_t;

	st_t          st_q;
	logic [31:0]  w_q [16];
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [60:0]  cnt_q;
	logic         fin_q;     // block being compressed is the final one
	logic         len_q;     // final block still needs the length
	logic         ovalid_q;
	logic [31:0]  out_q [5];

	logic [31:0]  f, k, wn, tmp, w_new, w_byte, mask;
	logic [5:0]   pos;
	logic [3:0]   wi;
	logic [4:0]   sh;

	assign pos = cnt_q[5:0];
	assign wi  = pos[5:2];
	assign sh  = {~pos[1:0], 3'b000};

	// Back end takes a command only from idle and with the output slot free
	// for a finishing item.
	assign cmd_take = (st_q == ST_IDLE) && cmd_valid && !(cmd.last && ovalid_q);

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = d_q ^ (b_q & (c_q ^ d_q)); k = sha1_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = sha1_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q)); k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = sha1_pkg::K3;
		end
		wn    = (rnd_q < 7'd16) ? w_q[rnd_q[3:0]] :
		        sha1_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		tmp   = sha1_pkg::rotl(a_q, 5) + f + e_q + k + wn;
		mask  = ~(32'hFF << sh);
		w_byte = (w_q[wi] & mask) | (32'(cmd.data_byte) << sh);
		w_new  = 32'(sha1_pkg::PAD_BYTE) << sh;
	end

	assign empty        = !ovalid_q;
	assign digest_word0 = out_q[0];
	assign digest_word1 = out_q[1];
	assign digest_word2 = out_q[2];
	assign digest_word3 = out_q[3];
	assign digest_word4 = out_q[4];

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (cmd_take && cmd.has_byte) begin
					w_q[wi] <= w_byte;
				end
			end
			ST_PAD: begin
				// pad byte then zero the rest of the block
				for (int i = 0; i < 16; i++) begin
					if (4'(i) > wi) begin
						w_q[i] <= '0;
					end
				end
				w_q[wi] <= (w_q[wi] & ~(32'hFFFFFFFF >> {pos[1:0], 3'b000})) | w_new;
			end
			ST_LEN: begin
				if (!len_q) begin
					for (int i = 0; i < 14; i++) w_q[i] <= '0;
				end
				w_q[14] <= {cnt_q[60:29]};
				w_q[15] <= {cnt_q[28:0], 3'b000};
			end
			ST_RUN: begin
				a_q <= tmp; b_q <= a_q; c_q <= sha1_pkg::rotl(b_q, 30);
				d_q <= c_q; e_q <= d_q;
				if (rnd_q >= 7'd16) begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
				end
			end
			ST_FOLD: begin
				if (fin_q) begin
					out_q[0] <= h_q[0] + a_q; out_q[1] <= h_q[1] + b_q;
					out_q[2] <= h_q[2] + c_q; out_q[3] <= h_q[3] + d_q;
					out_q[4] <= h_q[4] + e_q;
				end
			end
			default: ;
		endcase
		if (st_q != ST_RUN) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			rnd_q    <= '0;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			len_q    <= 1'b0;
			ovalid_q <= 1'b0;
			h_q[0] <= sha1_pkg::IV0; h_q[1] <= sha1_pkg::IV1; h_q[2] <= sha1_pkg::IV2;
			h_q[3] <= sha1_pkg::IV3; h_q[4] <= sha1_pkg::IV4;
		end else begin
			if (pop && ovalid_q) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.has_byte) begin
							cnt_q <= cnt_q + 61'd1;
						end
						fin_q <= 1'b0;
						if (cmd.has_byte && pos == 6'd63) begin
							len_q <= cmd.last;
							st_q  <= ST_RUN;
						end else if (cmd.last) begin
							st_q <= ST_PAD;
						end
						if (cmd.has_byte && pos == 6'd63 && cmd.last) begin
							// full block first, then a block of pad and length
						end
					end
				end
				ST_PAD: begin
					if (pos >= 6'd56) begin
						len_q <= 1'b1;
						fin_q <= 1'b0;
						st_q  <= ST_RUN;
					end else begin
						len_q <= 1'b1;
						st_q  <= ST_LEN;
					end
				end
				ST_LEN: begin
					fin_q <= 1'b1;
					len_q <= 1'b0;
					st_q  <= ST_RUN;
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) begin
						rnd_q <= '0;
						st_q  <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (fin_q) begin
						st_q     <= ST_OUT;
					end else if (len_q) begin
						// after a pad block a block of zeros and length follows; after a full block, padding
						st_q  <= ST_LEN;
						len_q <= 1'b0;
						if (pos == 6'd0) begin
							// byte filled a block then last: pad goes in a fresh block
							st_q <= ST_PAD;
							len_q <= 1'b0;
						end
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					cnt_q    <= '0;
					h_q[0] <= sha1_pkg::IV0; h_q[1] <= sha1_pkg::IV1;
					h_q[2] <= sha1_pkg::IV2; h_q[3] <= sha1_pkg::IV3;
					h_q[4] <= sha1_pkg::IV4;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ tb/sha1_hash_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Feeds byte messages, predicts each digest with an in-bench SHA-1 and checks
// every popped digest in order. Directed vectors first, then random messages
// under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module sha1_hash_engine_tb;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        last;
	logic        empty;
	logic        pop;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	typedef logic [159:0] digest_t;

	// Predictor state: chaining value, block being filled, byte count.
	logic [31:0] hash_state [5];
	logic [31:0] blk [16];
	logic [60:0] byte_count;

	digest_t digest_q[$];
	int      errors;
	int      send_idle_pct;
	int      recv_idle_pct;

	sha1_hash_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last         (last),
		.empty        (empty),
		.pop          (pop),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3),
		.digest_word4 (digest_word4)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// One 80-round compression of blk into hash_state.
	task automatic pred_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = blk[r];
		for (int r = 16; r < 80; r++)
			w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
		d = hash_state[3]; e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = d ^ (b & (c ^ d)); k = sha1_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = sha1_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (d & (b | c)); k = sha1_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sha1_pkg::K3;
			end
			t = rol(a, 5) + f + e + k + w[r];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
		hash_state[3] += d; hash_state[4] += e;
	endtask

	task automatic place_byte(input int pos, input logic [7:0] v);
		int sh;
		sh = (3 - (pos % 4)) * 8;
		blk[pos / 4][sh +: 8] = v;
	endtask

	task automatic sha1_restart();
		hash_state[0] = sha1_pkg::IV0; hash_state[1] = sha1_pkg::IV1;
		hash_state[2] = sha1_pkg::IV2; hash_state[3] = sha1_pkg::IV3;
		hash_state[4] = sha1_pkg::IV4;
		for (int i = 0; i < 16; i++)
			blk[i] = '0;
		byte_count = '0;
	endtask

	// Update the predictor for one accepted item; queue a digest on last.
	task automatic sha1_absorb(input logic [7:0] b, input logic hb, input logic lst);
		int      pos;
		logic [63:0] bits;
		if (hb) begin
			pos = int'(byte_count[5:0]);
			place_byte(pos, b);
			byte_count = byte_count + 1'b1;
			if (pos == 63)
				pred_compress();
		end
		if (lst) begin
			pos = int'(byte_count[5:0]);
			for (int i = pos; i < 64; i++)
				place_byte(i, 8'h00);
			place_byte(pos, sha1_pkg::PAD_BYTE);
			if (pos >= 56) begin
				pred_compress();
				for (int i = 0; i < 16; i++)
					blk[i] = '0;
			end
			bits = {byte_count, 3'b000};
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			pred_compress();
			digest_q.push_back({hash_state[0], hash_state[1], hash_state[2],
				hash_state[3], hash_state[4]});
			sha1_restart();
		end
	endtask

	// Send one item, idling beforehand at the current sender rate.
	task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		has_byte  <= hb;
		last      <= lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sha1_absorb(b, hb, lst);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom), 1'b1, 1'b0);
		send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Receiver: pops with random stalls and checks against the oldest digest.
	always @(posedge clk) begin
		digest_t got, want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = {digest_word0, digest_word1, digest_word2, digest_word3,
					digest_word4};
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest %h", $time, got);
					errors++;
				end else begin
					want = digest_q.pop_front();
					if (got !== want) begin
						$display("%0t: digest mismatch expected %h actual %h",
							$time, want, got);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Known digests, byte patterns at the extremes, padding boundaries at 55, 56, 63 and 64 bytes.
	task automatic test_directed();
		send_item(8'h00, 1'b0, 1'b1);             // empty message
		send_item(8'h61, 1'b1, 1'b0);             // "abc", last with byte
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);             // ignored item
		send_item(8'hAA, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		// Pause the sender until all results are back.
		wait_drain();
		send_message(55);                         // length fits one block
		send_message(56);                         // needs extra block
		send_message(63);
		send_message(64);                         // exact block
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_item(8'($urandom), 1'($urandom), 1'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(200)
					: $urandom_range(70);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(15) == 0) begin
						send_item(8'($urandom), 1'b0, 1'b0);
						sent++;
					end
					send_item(8'($urandom), 1'b1, 1'b0);
				end
				send_item(8'($urandom), 1'($urandom), 1'b1);
				sent += len + 1;
			end
		end
	endtask

	initial begin
		errors        = 0;
		arst_n        = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		data_byte     = '0;
		has_byte      = 1'b0;
		last          = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 73;
		sha1_restart();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(340);
		send_idle_pct = 73;
		recv_idle_pct = 17;
		test_random(340);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(350);
		wait_drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sha1_hash_engine.f @@
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_back.sv
rtl/sha1_hash_engine.sv
tb/sha1_hash_engine_tb.sv
